// ===== src/mfc_pkg.sv =====
// Shared types and constants for the meter frame checker.
`timescale 1ns / 1ps

package mfc_pkg;

  localparam int DefMaxFrameBytes = 256;
  localparam int StartCode        = 8'h68;
  localparam int StopCode         = 8'h16;
  localparam int SecondStartPos   = 7;
  localparam int ControlPos       = 8;
  localparam int AddrBytes        = 6;
  localparam int MinFrameBytes    = 10;
  localparam int DirBit           = 7;
  localparam int ErrBit           = 6;
  localparam int AddrW            = 48;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_REJECT = 2'd1,
    VERDICT_ERROR  = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    verdict_t   verdict;
    logic [7:0] error_code;
  } out_item_t;

endpackage

// ===== src/meter_frame_checker_core.sv =====
// Top level of the meter frame checker: byte-wise frame validation with one verdict per frame.
`timescale 1ns / 1ps

// Channel   Direction  Payload        Transaction
// in        to core    in_item_t      one received frame byte, last_byte marks the end
// out       from core  out_item_t     one verdict and error code per completed frame
// cfg       to core    48-bit data    new slave address, cfg_ready is always high
//
// The core takes one byte per cycle. Each byte updates the running state in the
// cycle it is accepted; a final byte loads the result register, so its verdict
// appears in the cycle after acceptance. Input is stalled only while a verdict waits
// in the result register and the consumer holds out_ready low. Reset (synchronous,
// active high) clears the frame state, the result register and the address.
module meter_frame_checker_core import mfc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [AddrW-1:0] cfg_data
);

  // The count only has to reach the saturation limit.
  localparam int CountW = $clog2(MAX_FRAME_BYTES + 1);

  logic [AddrW-1:0]  slave_address;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [7:0]        lagged_sum, lagged_sum_next;
  logic [7:0]        recent0, recent0_next;
  logic [7:0]        recent1, recent1_next;
  logic [7:0]        control_byte, control_byte_next;
  logic              start_codes_ok, start_codes_ok_next;
  logic              address_matches, address_matches_next;

  logic              in_fire;
  logic              too_long;
  logic [2:0]        addr_idx;
  logic [5:0]        addr_shift;
  logic [7:0]        addr_expect;
  out_item_t         result;

  assign cfg_ready = 1'b1;
  // The result register parts the two sides: a new byte enters whenever the
  // waiting verdict, if any, leaves in the same cycle.
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;

  assign too_long    = byte_count >= CountW'(MAX_FRAME_BYTES);
  // Frame bytes 1..6 carry the address, lowest register byte first.
  assign addr_idx    = 3'(byte_count - CountW'(1));
  assign addr_shift  = {addr_idx, 3'b000};
  assign addr_expect = 8'(slave_address >> addr_shift);

  always_comb begin
    byte_count_next      = byte_count;
    start_codes_ok_next  = start_codes_ok;
    address_matches_next = address_matches;
    control_byte_next    = control_byte;

    // Bytes past the length limit are no longer examined.
    if (!too_long) begin
      if ((byte_count == CountW'(0)) || (byte_count == CountW'(SecondStartPos))) begin
        if (in_data.frame_byte != 8'(StartCode)) start_codes_ok_next = 1'b0;
      end
      if ((byte_count >= CountW'(1)) && (byte_count <= CountW'(AddrBytes))) begin
        if (in_data.frame_byte != addr_expect) address_matches_next = 1'b0;
      end
      if (byte_count == CountW'(ControlPos)) control_byte_next = in_data.frame_byte;
      byte_count_next = byte_count + CountW'(1);
    end

    // The sum trails the newest byte by two places, so once the frame ends it
    // covers everything but the checksum and stop bytes.
    lagged_sum_next = (byte_count >= CountW'(2)) ? 8'(lagged_sum + recent1) : lagged_sum;
    recent1_next    = recent0;
    recent0_next    = in_data.frame_byte;
  end

  // Verdict for a final byte; the first failing check decides.
  always_comb begin
    result.verdict    = VERDICT_ACCEPT;
    result.error_code = 8'd0;
    if (too_long || (byte_count < CountW'(MinFrameBytes - 1))) begin
      result.verdict = VERDICT_REJECT;
    end else if (!start_codes_ok_next || (in_data.frame_byte != 8'(StopCode))) begin
      result.verdict = VERDICT_REJECT;
    end else if (lagged_sum_next != recent0) begin
      result.verdict = VERDICT_REJECT;
    end else if (!control_byte_next[DirBit]) begin
      // A master command has no business arriving here.
      result.verdict = VERDICT_REJECT;
    end else if (control_byte_next[ErrBit]) begin
      // Error replies carry their code just ahead of the checksum byte, and
      // the address is not checked for them.
      result.verdict    = VERDICT_ERROR;
      result.error_code = recent1;
    end else if (!address_matches_next) begin
      result.verdict = VERDICT_REJECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      slave_address <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      lagged_sum      <= '0;
      recent0         <= '0;
      recent1         <= '0;
      control_byte    <= '0;
      start_codes_ok  <= 1'b1;
      address_matches <= 1'b1;
    end else if (in_fire) begin
      if (in_data.last_byte) begin
        // The frame is done; start clean for the next one.
        byte_count      <= '0;
        lagged_sum      <= '0;
        recent0         <= '0;
        recent1         <= '0;
        control_byte    <= '0;
        start_codes_ok  <= 1'b1;
        address_matches <= 1'b1;
      end else begin
        byte_count      <= byte_count_next;
        lagged_sum      <= lagged_sum_next;
        recent0         <= recent0_next;
        recent1         <= recent1_next;
        control_byte    <= control_byte_next;
        start_codes_ok  <= start_codes_ok_next;
        address_matches <= address_matches_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && in_data.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_data.last_byte) begin
      out_data <= result;
    end
  end

  // A final byte always leaves a verdict waiting in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.last_byte |=> out_valid)
    else $error("final byte did not produce a verdict");

  // The frame state starts over after a final byte.
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.last_byte |=> byte_count == '0 && start_codes_ok && address_matches)
    else $error("frame state not cleared after final byte");

  // The byte count saturates at the length limit.
  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CountW'(MAX_FRAME_BYTES))
    else $error("byte count beyond limit");

  // Only an error reply carries a nonzero error code.
  a_code_only_on_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.verdict != VERDICT_ERROR) |-> out_data.error_code == 8'd0)
    else $error("error code on a non-error verdict");

endmodule

// ===== bench/tb_meter_frame_checker_core.sv =====
// Testbench for meter_frame_checker_core: random meter frames checked against a predictor.
`timescale 1ns / 1ps

module tb_meter_frame_checker_core;
  import mfc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int PhaseBytes = 180;

  typedef enum int {
    FLAW_NONE,
    FLAW_FIRST_START,
    FLAW_SECOND_START,
    FLAW_STOP,
    FLAW_SUM,
    FLAW_NOISE
  } frame_flaw_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [AddrW-1:0] cfg_data = '0;

  meter_frame_checker_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  pending_bytes[$];
  out_item_t verdicts_due[$];
  int        errors = 0;
  int        bytes_queued = 0;
  int        cycles = 0;
  logic      idling = 1'b1;
  logic      pressure_armed = 1'b0;
  logic      backlog_hold = 1'b0;
  logic      hold_done = 1'b0;
  int        hold_left = 0;
  int        send_gap = 0;
  int        recv_gap = 0;

  // Predictor copy of the frame state and of the station address.
  int               frame_len;
  logic [7:0]       tail_sum;
  logic [7:0]       newest_byte;
  logic [7:0]       prior_byte;
  logic [7:0]       ctrl_seen;
  logic             starts_good;
  logic             addr_good;
  logic [AddrW-1:0] station_addr;

  task automatic clear_frame_state();
    frame_len   = 0;
    tail_sum    = '0;
    newest_byte = '0;
    prior_byte  = '0;
    ctrl_seen   = '0;
    starts_good = 1'b1;
    addr_good   = 1'b1;
  endtask

  // Advances the predicted frame state by one byte and, on a final byte, queues the verdict.
  task automatic absorb_byte(input in_item_t it);
    int         n;
    logic       too_long;
    logic [7:0] sum_byte;
    logic [7:0] err_byte;
    out_item_t  v;
    n = frame_len;
    too_long = (n >= DefMaxFrameBytes);
    if (!too_long) begin
      if ((n == 0 || n == SecondStartPos) && it.frame_byte != 8'(StartCode)) begin
        starts_good = 1'b0;
      end
      if (n >= 1 && n <= AddrBytes && it.frame_byte != station_addr[8*(n-1) +: 8]) begin
        addr_good = 1'b0;
      end
      if (n == ControlPos) begin
        ctrl_seen = it.frame_byte;
      end
      frame_len = n + 1;
    end
    sum_byte = newest_byte;
    err_byte = prior_byte;
    if (n >= 2) begin
      tail_sum = tail_sum + prior_byte;
    end
    prior_byte = newest_byte;
    newest_byte = it.frame_byte;
    if (it.last_byte) begin
      v.error_code = '0;
      if (too_long || n + 1 < MinFrameBytes) begin
        v.verdict = VERDICT_REJECT;
      end else if (!starts_good || it.frame_byte != 8'(StopCode)) begin
        v.verdict = VERDICT_REJECT;
      end else if (tail_sum != sum_byte) begin
        v.verdict = VERDICT_REJECT;
      end else if (!ctrl_seen[DirBit]) begin
        v.verdict = VERDICT_REJECT;
      end else if (ctrl_seen[ErrBit]) begin
        v.verdict = VERDICT_ERROR;
        v.error_code = err_byte;
      end else if (!addr_good) begin
        v.verdict = VERDICT_REJECT;
      end else begin
        v.verdict = VERDICT_ACCEPT;
      end
      verdicts_due.push_back(v);
      clear_frame_state();
    end
  endtask

  // Builds a frame of the given length and queues its bytes. A well-formed frame carries
  // both start codes, the address, the control byte, a valid checksum and the stop code.
  task automatic send_frame(input int len, input logic [7:0] ctrl,
                            input logic [AddrW-1:0] addr, input frame_flaw_t flaw);
    logic [7:0] fb[];
    logic [7:0] sum;
    in_item_t   it;
    fb = new[len];
    foreach (fb[i]) fb[i] = 8'($urandom);
    if (flaw != FLAW_NOISE) begin
      fb[0] = 8'(StartCode);
      for (int i = 1; i <= AddrBytes && i < len; i++) fb[i] = addr[8*(i-1) +: 8];
      if (len > SecondStartPos) fb[SecondStartPos] = 8'(StartCode);
      if (len > ControlPos) fb[ControlPos] = ctrl;
      // In a ten-byte frame the checksum lands on the control byte.
      if (len >= 2) begin
        sum = '0;
        for (int i = 0; i < len - 2; i++) sum = sum + fb[i];
        fb[len-2] = sum;
      end
      fb[len-1] = 8'(StopCode);
    end
    case (flaw)
      FLAW_FIRST_START: fb[0] = fb[0] ^ 8'($urandom_range(1, 255));
      FLAW_SECOND_START: begin
        if (len > SecondStartPos) fb[SecondStartPos] ^= 8'($urandom_range(1, 255));
      end
      FLAW_STOP: fb[len-1] = fb[len-1] ^ 8'($urandom_range(1, 255));
      FLAW_SUM: begin
        if (len >= 2) fb[len-2] = fb[len-2] ^ 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      it.frame_byte = fb[i];
      it.last_byte  = (i == len - 1);
      pending_bytes.push_back(it);
    end
    bytes_queued += len;
  endtask

  task automatic send_random_frame();
    int               len;
    int               pick;
    logic [7:0]       ctrl;
    logic [AddrW-1:0] addr;
    frame_flaw_t      flaw;
    pick = $urandom_range(0, 19);
    if (pick == 0) len = $urandom_range(1, 9);
    else if (pick == 1) len = $urandom_range(21, 40);
    else len = $urandom_range(10, 20);
    ctrl = 8'($urandom);
    ctrl[DirBit] = ($urandom_range(0, 9) != 0);
    ctrl[ErrBit] = ($urandom_range(0, 3) == 0);
    addr = station_addr;
    if ($urandom_range(0, 4) == 0) begin
      addr = addr ^ (AddrW'($urandom_range(1, 255)) << (8 * $urandom_range(0, AddrBytes - 1)));
    end
    flaw = FLAW_NONE;
    if ($urandom_range(0, 19) >= 13) flaw = frame_flaw_t'($urandom_range(1, 5));
    send_frame(len, ctrl, addr, flaw);
  endtask

  task automatic send_random_phase();
    bytes_queued = 0;
    while (bytes_queued < PhaseBytes) send_random_frame();
  endtask

  // Waits until every queued byte is in and every verdict is out, then lets the core settle.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_station(input logic [AddrW-1:0] a);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    station_addr = a;
    cfg_valid <= 1'b0;
  endtask

  // Byte sender: predicts on each accepted transaction and inserts short idle bursts.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_byte(in_data);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 2);
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_bytes.pop_front();
        end
      end
    end
  end

  // One long hold-off of the verdict consumer, so the core backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      backlog_hold <= 1'b0;
      hold_done    <= 1'b0;
      hold_left    <= 0;
    end else if (pressure_armed && !hold_done) begin
      if (!backlog_hold) begin
        backlog_hold <= 1'b1;
        hold_left    <= HoldCycles;
      end else if (hold_left == 0) begin
        backlog_hold <= 1'b0;
        hold_done    <= 1'b1;
      end else begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Verdict checker and consumer stalls.
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: verdict with none expected: actual verdict %0d code %0h",
                   $time, out_data.verdict, out_data.error_code);
          errors++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_data.verdict != want.verdict) begin
            $display("%0t: verdict mismatch: expected %0d actual %0d",
                     $time, want.verdict, out_data.verdict);
            errors++;
          end
          if (out_data.error_code != want.error_code) begin
            $display("%0t: error_code mismatch: expected %0h actual %0h",
                     $time, want.error_code, out_data.error_code);
            errors++;
          end
        end
      end
      if (backlog_hold) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        recv_gap  <= $urandom_range(0, 2);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    clear_frame_state();
    station_addr = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset address of zero: a lone all-ones final byte, a ten-byte
    // frame whose control byte doubles as checksum (here an error reply), a frame one byte
    // too short, and a plain accepted frame.
    pending_bytes.push_back('{frame_byte: 8'hFF, last_byte: 1'b1});
    send_frame(10, 8'h00, '0, FLAW_NONE);
    send_frame(9, 8'h80, '0, FLAW_NONE);
    send_frame(12, 8'h91, '0, FLAW_NONE);
    wait_drained();

    // All-ones address and the two frames around the length limit: exactly at it and one
    // byte over. Then short frames with the consumer holding off, so the core backs up.
    write_station({AddrW{1'b1}});
    send_frame(DefMaxFrameBytes, 8'h81, station_addr, FLAW_NONE);
    send_frame(DefMaxFrameBytes + 1, 8'h81, station_addr, FLAW_NONE);
    wait_drained();
    send_random_phase();
    pressure_armed = 1'b1;
    wait_drained();

    write_station('0);
    send_random_phase();
    wait_drained();

    write_station(AddrW'({$urandom, $urandom}));
    idling = 1'b0;
    send_random_phase();
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
